// ----- src/bis_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bounded id set
// Operation codes, result codes and the per-cell control word.
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int ID_W = 32;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_TAKE   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic [ID_W-1:0] NO_ID = {ID_W{1'b1}};

   typedef struct packed {
      logic load;   // write the request id into this cell
      logic shift;  // take the entry of the next cell up
   } bis_cell_ctl_type;

endpackage : bis_pkg
`default_nettype wire

// ----- src/bis_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bis_cell: one storage cell of the id chain
// Holds one identifier, compares it against the broadcast key and takes
// either the key or its upper neighbour's entry on command.
// ----------------------------------------------------------------------------
module bis_cell
   import bis_pkg::*;
(
   input  logic             clock,
   input  logic [ID_W-1:0]  key,
   input  logic [ID_W-1:0]  next_entry,
   input  logic             occupied,
   input  bis_cell_ctl_type ctl,
   output logic [ID_W-1:0]  entry,
   output logic             match
);

   logic [ID_W-1:0] entry_ff, entry_in;
   logic            match_ff, match_in;

   always_comb begin
      priority if (ctl.load) begin
         entry_in = key;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
      match_in = occupied && (entry_ff == key);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule : bis_cell
`default_nettype wire

// ----- src/bis_match_enc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bis_match_enc: match vector encoder
// Entries are unique, so at most one cell matches; the index is an or-tree
// of the matching positions.
// ----------------------------------------------------------------------------
module bis_match_enc #(
   parameter int CAPACITY = 64,
   parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic [CAPACITY-1:0] match,
   output logic                found,
   output logic [IDX_W-1:0]    index
);

   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            index = index | IDX_W'(i);
         end
      end
      found = |match;
   end

endmodule : bis_match_enc
`default_nettype wire

// ----- src/bounded_id_set_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_id_set_top: bounded insertion-ordered set of signed identifiers
// A row of cells, one per slot, compares all entries against the request in
// parallel; take compacts the row by a one-place neighbour shift.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, id_value
//   rsp      out        rsp_valid/rsp_stall  status, found, match_index,
//                                            taken_id, entry_count
//
// Each request passes through the registered compare in the cells (ST_CMP),
// then the encoding of the match and the update of cells and count (ST_UPD).
// A new request is taken in the update cycle of the previous one.
// Reset clears the count and the handshake state; no clearing pass.
// A stalled response holds the update cycle until the output register frees.
// ----------------------------------------------------------------------------
module bounded_id_set_top
   import bis_pkg::*;
#(
   parameter int CAPACITY = 64,
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic signed [ID_W-1:0] req_id_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_status,
   output logic                   rsp_found,
   output logic [IDX_W-1:0]       rsp_match_index,
   output logic signed [ID_W-1:0] rsp_taken_id,
   output logic [CNT_W-1:0]       rsp_entry_count
);

   typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_type;

   state_type        state_ff, state_in;
   logic [1:0]       op_ff;
   logic [ID_W-1:0]  id_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             status_ff, status_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [ID_W-1:0]  taken_ff, taken_in;

   logic [ID_W-1:0]        entry_q [CAPACITY];
   logic [CAPACITY-1:0]    match_q;
   logic [CAPACITY-1:0]    occupied;
   bis_cell_ctl_type       cell_ctl [CAPACITY];

   logic             hit;
   logic [IDX_W-1:0] hit_index;
   logic             out_free, upd_go, req_xfer;
   logic             add_ok, take_ok;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign upd_go    = (state_ff == ST_UPD) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || upd_go);
   assign req_xfer  = req_valid && !req_stall;

   // cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_W-1:0] upper;
      if (g == CAPACITY - 1) begin : g_last
         assign upper = entry_q[g];
      end else begin : g_mid
         assign upper = entry_q[g+1];
      end
      bis_cell u_cell (
         .clock      (clock),
         .key        (id_ff),
         .next_entry (upper),
         .occupied   (occupied[g]),
         .ctl        (cell_ctl[g]),
         .entry      (entry_q[g]),
         .match      (match_q[g])
      );
   end

   bis_match_enc #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_enc (
      .match (match_q),
      .found (hit),
      .index (hit_index)
   );

   // result and count update
   always_comb begin
      add_ok    = 1'b0;
      take_ok   = 1'b0;
      status_in = STATUS_OK;
      found_in  = hit;
      index_in  = hit_index;
      taken_in  = NO_ID;
      count_in  = count_ff;
      unique case (op_ff)
         OP_ADD: begin
            if (id_ff[ID_W-1] && (id_ff != NO_ID)) begin
               status_in = STATUS_ERR;
            end else if (hit) begin
               status_in = STATUS_OK;
            end else if (count_ff >= CNT_W'(CAPACITY)) begin
               status_in = STATUS_ERR;
            end else begin
               add_ok   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_FIND: begin
            status_in = STATUS_OK;
         end
         OP_TAKE: begin
            if (!hit) begin
               status_in = STATUS_ERR;
            end else begin
               take_ok  = 1'b1;
               taken_in = id_ff;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STATUS_ERR;
            found_in  = 1'b0;
            index_in  = '0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occupied[i]       = CNT_W'(i) < count_ff;
         cell_ctl[i].load  = upd_go && add_ok && (CNT_W'(i) == count_ff);
         // cells at and above the removed one take their neighbour's entry
         cell_ctl[i].shift = upd_go && take_ok && (IDX_W'(i) >= hit_index);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_CMP;
         ST_CMP:  state_in = ST_UPD;
         ST_UPD: begin
            if (upd_go) begin
               rsp_valid_in = 1'b1;
               state_in     = req_xfer ? ST_CMP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_go) begin
            count_ff <= count_in;
         end
      end
      if (req_xfer) begin
         op_ff <= req_operation;
         id_ff <= req_id_value;
      end
      if (upd_go) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         index_ff  <= found_in ? index_in : '0;
         taken_ff  <= taken_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_match_index = index_ff;
   assign rsp_taken_id    = taken_ff;
   assign rsp_entry_count = count_ff;

endmodule : bounded_id_set_top
`default_nettype wire

// ----- bench/tb_bounded_id_set_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bounded_id_set_top: self-checking bench for the bounded id set
// Directed add, find and take requests cover the id extremes, rejected and
// duplicate adds, a full set and the unused operation. Random traffic follows
// over id pools of several sizes. A local set model predicts every reply, and
// each reply transfer is checked field by field, in order, against it.
// Requests idle and replies stall at random.
// ----------------------------------------------------------------------------
module tb_bounded_id_set_top
   import bis_pkg::*;
();

   localparam int SET_CAPACITY = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic            status;
      logic            found;
      logic [5:0]      match_index;
      logic [ID_W-1:0] taken_id;
      logic [6:0]      entry_count;
   } set_reply_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_operation = OP_ADD;
   logic signed [ID_W-1:0] req_id_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_status;
   logic                   rsp_found;
   logic [5:0]             rsp_match_index;
   logic signed [ID_W-1:0] rsp_taken_id;
   logic [6:0]             rsp_entry_count;

   // set model: identifiers in insertion order
   logic [ID_W-1:0] set_ids [SET_CAPACITY];
   int              set_count = 0;

   set_reply_type   pending_replies [$];
   logic [ID_W-1:0] id_pool [128];
   int              error_count = 0;
   int              cycle_count = 0;
   int              gap_limit = 0;
   int              burst_left = 0;
   int              hold_off_left = 0;
   int              hold_off_requests = 0;
   int              hold_off_seen = 0;
   stall_mode_type  stall_mode = STALL_NONE;
   logic [15:0]     stall_pattern = 16'b0110_0000_1110_0100;

   bounded_id_set_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_id_value    (req_id_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_taken_id    (rsp_taken_id),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_bounded_id_set_top failed");
         $finish;
      end
   end

   // receiver: long hold-off when asked, otherwise the current stall mode
   always @(posedge clock) begin
      if (hold_off_seen != hold_off_requests) begin
         hold_off_seen <= hold_off_requests;
         hold_off_left <= HOLD_CYCLES;
         rsp_stall     <= 1'b1;
      end else if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         case (stall_mode)
            STALL_NONE:    rsp_stall <= 1'b0;
            STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PATTERN: rsp_stall <= stall_pattern[cycle_count % 16];
            default:       rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic set_reply_type predict_reply(input logic [1:0] op,
                                                   input logic [ID_W-1:0] id);
      set_reply_type r;
      int            pos;
      int            i;
      pos = -1;
      for (i = 0; i < set_count; i++)
         if (pos < 0 && set_ids[i] == id)
            pos = i;
      r.status      = STATUS_OK;
      r.found       = (pos >= 0);
      r.match_index = (pos >= 0) ? pos[5:0] : 6'd0;
      r.taken_id    = NO_ID;
      case (op)
         OP_ADD: begin
            // anything negative other than minus one is not a valid id
            if (id[ID_W-1] && id != NO_ID)
               r.status = STATUS_ERR;
            else if (pos < 0) begin
               if (set_count >= SET_CAPACITY)
                  r.status = STATUS_ERR;
               else begin
                  set_ids[set_count] = id;
                  set_count++;
               end
            end
         end
         OP_FIND: begin
         end
         OP_TAKE: begin
            if (pos < 0)
               r.status = STATUS_ERR;
            else begin
               r.taken_id = set_ids[pos];
               for (i = pos; i + 1 < set_count; i++)
                  set_ids[i] = set_ids[i + 1];
               set_count--;
            end
         end
         default: begin
            r.status      = STATUS_ERR;
            r.found       = 1'b0;
            r.match_index = 6'd0;
         end
      endcase
      r.entry_count = set_count[6:0];
      return r;
   endfunction

   always @(posedge clock) begin : reply_check
      set_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("reply transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               error_count++;
            end
            if (rsp_match_index !== want.match_index) begin
               $error("match_index: expected %0d, got %0d",
                      want.match_index, rsp_match_index);
               error_count++;
            end
            if (rsp_taken_id !== want.taken_id) begin
               $error("taken_id: expected %0d, got %0d",
                      $signed(want.taken_id), rsp_taken_id);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // valid stays high across back-to-back requests; it drops only in a gap
   task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id);
      int gap;
      if (gap_limit > 0 && burst_left == 0) begin
         gap = $urandom_range(1, gap_limit);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_id_value  <= id;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(predict_reply(op, id));
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic test_directed();
      stall_mode = STALL_RANDOM;
      gap_limit  = 3;
      send_request(OP_FIND, 32'd0);
      send_request(OP_TAKE, 32'd0);
      send_request(OP_ADD,  32'd0);
      send_request(OP_ADD,  NO_ID);
      send_request(OP_ADD,  32'h7FFF_FFFF);
      send_request(OP_ADD,  32'hFFFF_FFFE);
      send_request(OP_ADD,  32'h8000_0000);
      send_request(OP_ADD,  32'd0);
      send_request(OP_FIND, NO_ID);
      send_request(OP_FIND, 32'h7FFF_FFFF);
      send_request(OP_FIND, 32'h8000_0000);
      send_request(OP_UNUSED, 32'd0);
      send_request(OP_UNUSED, 32'h8000_0000);
      send_request(OP_TAKE, NO_ID);
      send_request(OP_FIND, 32'h7FFF_FFFF);
      send_request(OP_TAKE, 32'd5);
      send_request(OP_ADD,  32'h5555_5555);
      send_request(OP_ADD,  32'h2AAA_AAAA);
      send_request(OP_FIND, 32'h2AAA_AAAA);
      send_request(OP_TAKE, 32'd0);
      send_request(OP_TAKE, 32'h2AAA_AAAA);
      send_request(OP_TAKE, 32'h7FFF_FFFF);
      send_request(OP_TAKE, 32'h5555_5555);
      send_request(OP_TAKE, 32'h5555_5555);
      wait_for_replies();
   endtask

   task automatic test_full_set();
      int k;
      stall_mode = STALL_PATTERN;
      gap_limit  = 4;
      for (k = 0; k < SET_CAPACITY; k++)
         send_request(OP_ADD, k * 32'h0101_0101);
      send_request(OP_ADD,  32'h0001_2345);
      send_request(OP_ADD,  10 * 32'h0101_0101);
      send_request(OP_FIND, 63 * 32'h0101_0101);
      send_request(OP_TAKE, 32'd0);
      send_request(OP_FIND, 63 * 32'h0101_0101);
      send_request(OP_TAKE, 63 * 32'h0101_0101);
      // empty the set in random order; the model is up to date after each send
      while (set_count > 0)
         send_request(OP_TAKE, set_ids[$urandom_range(0, set_count - 1)]);
      wait_for_replies();
   endtask

   task automatic test_random_traffic(input int n_items, input int pool_size,
                                      input stall_mode_type mode, input int gaps);
      int              k;
      int              pick;
      int              weight;
      logic [1:0]      op;
      logic [ID_W-1:0] id;
      stall_mode = mode;
      gap_limit  = gaps;
      for (k = 0; k < pool_size; k++)
         id_pool[k] = $urandom() & 32'h7FFF_FFFF;
      id_pool[0] = NO_ID;
      id_pool[1] = 32'd0;
      id_pool[2] = 32'h7FFF_FFFF;
      for (k = 0; k < n_items; k++) begin
         pick   = $urandom_range(0, 99);
         weight = $urandom_range(0, 9);
         id     = id_pool[$urandom_range(0, pool_size - 1)];
         if (weight < 4)
            op = OP_ADD;
         else if (weight < 7)
            op = OP_FIND;
         else
            op = OP_TAKE;
         if (pick >= 95)
            op = OP_UNUSED;
         else if (pick >= 85) begin
            id = $urandom();
            op = 2'($urandom_range(0, 2));
         end
         send_request(op, id);
      end
      wait_for_replies();
   endtask

   task automatic test_back_pressure();
      int k;
      stall_mode = STALL_NONE;
      gap_limit  = 0;
      hold_off_requests++;
      for (k = 0; k < 40; k++)
         send_request((k % 3 == 2) ? OP_TAKE : OP_ADD, k / 2);
      wait_for_replies();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_set();
      test_random_traffic(400, 16, STALL_NONE, 0);
      test_random_traffic(400, 100, STALL_RANDOM, 6);
      test_back_pressure();
      test_random_traffic(400, 48, STALL_PATTERN, 3);
      test_random_traffic(400, 100, STALL_HEAVY, 10);
      wait_for_replies();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0)
         $display("tb_bounded_id_set_top passed");
      else
         $display("tb_bounded_id_set_top failed");
      $finish;
   end

endmodule : tb_bounded_id_set_top
`default_nettype wire
